// File: rtl/tlpq_pkg.sv
// Shared constants and types of the three-level priority queue.
package tlpq_pkg;

	localparam int unsigned DEPTH_DEF      = 16;
	localparam int unsigned DATA_WIDTH_DEF = 16;
	localparam int unsigned MAX_BURST_DEF  = 4;

	localparam int unsigned LEVELS   = 3;
	localparam int unsigned PRI_W    = 2;
	localparam int unsigned COUNT_W  = 3;
	localparam int unsigned LEVEL_W  = 2;
	localparam int unsigned STATUS_W = 3;

	typedef enum logic [STATUS_W-1:0] {
		ST_ENQ    = 3'd0,
		ST_OVF    = 3'd1,
		ST_DEQ    = 3'd2,
		ST_UNF    = 3'd3,
		ST_BADPRI = 3'd4
	} status_t;

	typedef enum logic {
		FUNC_ENQ = 1'b0,
		FUNC_DEQ = 1'b1
	} func_t;

endpackage

// File: rtl/tlpq_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module tlpq_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 48
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		// hold read data until the next read
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/three_level_priority_queue.sv
// Top level of the three-level strict priority queue.
//
// Three circular FIFOs of DEPTH entries, one per priority level, share one RAM
// of 3*DEPTH words. An input beat with tuser 0 enqueues tdata's value at
// priority 1 (highest) to 3 and returns one result beat: enqueued, overflow
// when that level is full, or bad priority for priority 0. An input beat with
// tuser 1 dequeues 1 to MAX_BURST values, capped at 7 (count 0 reads as 1,
// larger counts saturate), each from the highest non-empty level, one result
// beat per value; if every level runs empty first an underflow beat closes
// the burst. tlast marks the final result beat of each input beat. One item
// is handled at a time; the single RAM read port delivers one value per cycle
// while the output is not stalled. The output register lets a finished
// result wait while the next beat is taken.
module three_level_priority_queue #(
	parameter int unsigned DEPTH      = tlpq_pkg::DEPTH_DEF,
	parameter int unsigned DATA_WIDTH = tlpq_pkg::DATA_WIDTH_DEF,
	parameter int unsigned MAX_BURST  = tlpq_pkg::MAX_BURST_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// data_in, priority_req, remove_count, zero padding
	input  logic [((DATA_WIDTH + tlpq_pkg::PRI_W + tlpq_pkg::COUNT_W + 7) / 8) * 8 - 1:0] s_tdata,
	// func
	input  logic s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// data_out, from_level, zero padding
	output logic [((DATA_WIDTH + tlpq_pkg::LEVEL_W + 7) / 8) * 8 - 1:0] m_tdata,
	// status
	output logic [tlpq_pkg::STATUS_W-1:0] m_tuser,
	output logic m_tlast
);

	localparam int unsigned PW   = $clog2(DEPTH);
	localparam int unsigned OW   = $clog2(DEPTH + 1);
	localparam int unsigned RAMD = tlpq_pkg::LEVELS * DEPTH;
	localparam int unsigned AW   = $clog2(RAMD);
	localparam int unsigned CW   = tlpq_pkg::COUNT_W;
	localparam int unsigned LW   = tlpq_pkg::LEVEL_W;
	localparam int unsigned BurstCap = (MAX_BURST > 7) ? 7 : MAX_BURST;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DEQ_WAIT
	} state_t;

	state_t state_q;

	logic                  func_q;
	logic [DATA_WIDTH-1:0] data_q;
	logic [tlpq_pkg::PRI_W-1:0] pri_q;
	logic [CW-1:0]         rem_q;
	logic [LW-1:0]         rd_lvl_s1;

	logic [PW-1:0] head_q [tlpq_pkg::LEVELS];
	logic [PW-1:0] tail_q [tlpq_pkg::LEVELS];
	logic [OW-1:0] occ_q  [tlpq_pkg::LEVELS];

	logic                  m_tvalid_q;
	logic [DATA_WIDTH-1:0] m_data_q;
	logic [LW-1:0]         m_level_q;
	tlpq_pkg::status_t     m_status_q;
	logic                  m_last_q;

	logic [DATA_WIDTH-1:0]      in_data;
	logic [tlpq_pkg::PRI_W-1:0] in_pri;
	logic [CW-1:0]              in_count;
	logic [CW-1:0]              burst_n;

	logic [tlpq_pkg::LEVELS-1:0] nonempty;
	logic                        any_data;
	logic [LW-1:0]               pick_lvl;
	logic [LW-1:0]               enq_lvl;
	logic                        out_free;
	logic                        rd_en;
	logic                        wr_en;
	logic                        enq_full;
	logic [AW-1:0]               rd_addr;
	logic [AW-1:0]               wr_addr;
	logic [DATA_WIDTH-1:0]       rd_data;

	function automatic logic [AW-1:0] level_base(input logic [LW-1:0] lvl);
		logic [AW-1:0] base;
		base = '0;
		if (lvl == 2'd1) begin
			base = AW'(DEPTH);
		end else if (lvl == 2'd2) begin
			base = AW'(2 * DEPTH);
		end
		return base;
	endfunction

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
	endfunction

	assign in_data  = s_tdata[DATA_WIDTH-1:0];
	assign in_pri   = s_tdata[DATA_WIDTH +: tlpq_pkg::PRI_W];
	assign in_count = s_tdata[DATA_WIDTH + tlpq_pkg::PRI_W +: CW];

	// zero asks for one value, large counts saturate
	always_comb begin
		if (in_count == '0) begin
			burst_n = CW'(1);
		end else if (in_count > CW'(BurstCap)) begin
			burst_n = CW'(BurstCap);
		end else begin
			burst_n = in_count;
		end
	end

	always_comb begin
		for (int i = 0; i < tlpq_pkg::LEVELS; i++) begin
			nonempty[i] = (occ_q[i] != '0);
		end
	end

	assign any_data = |nonempty;
	assign pick_lvl = nonempty[0] ? 2'd0 : (nonempty[1] ? 2'd1 : 2'd2);
	assign enq_lvl  = LW'(pri_q - 2'd1);
	assign enq_full = (occ_q[enq_lvl] == OW'(DEPTH));
	assign out_free = !m_tvalid_q || m_tready;

	assign s_tready = (state_q == S_IDLE);

	assign rd_en = ((state_q == S_EXEC) && (func_q == tlpq_pkg::FUNC_DEQ) && any_data) ||
		((state_q == S_DEQ_WAIT) && out_free && (rem_q != CW'(1)) && any_data);
	assign wr_en = (state_q == S_EXEC) && (func_q == tlpq_pkg::FUNC_ENQ) && out_free &&
		(pri_q != '0) && !enq_full;

	assign rd_addr = AW'(level_base(pick_lvl) + AW'(head_q[pick_lvl]));
	assign wr_addr = AW'(level_base(enq_lvl) + AW'(tail_q[enq_lvl]));

	tlpq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (RAMD)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (data_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
			m_last_q   <= 1'b0;
			m_status_q <= tlpq_pkg::ST_ENQ;
			for (int i = 0; i < tlpq_pkg::LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				occ_q[i]  <= '0;
			end
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (rd_en) begin
				head_q[pick_lvl] <= ptr_inc(head_q[pick_lvl]);
				occ_q[pick_lvl]  <= OW'(occ_q[pick_lvl] - 1'b1);
			end else if (wr_en) begin
				tail_q[enq_lvl] <= ptr_inc(tail_q[enq_lvl]);
				occ_q[enq_lvl]  <= OW'(occ_q[enq_lvl] + 1'b1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (func_q == tlpq_pkg::FUNC_ENQ) begin
						if (out_free) begin
							m_tvalid_q <= 1'b1;
							m_last_q   <= 1'b1;
							if (pri_q == '0) begin
								m_status_q <= tlpq_pkg::ST_BADPRI;
							end else if (enq_full) begin
								m_status_q <= tlpq_pkg::ST_OVF;
							end else begin
								m_status_q <= tlpq_pkg::ST_ENQ;
							end
							state_q <= S_IDLE;
						end
					end else if (any_data) begin
						state_q <= S_DEQ_WAIT;
					end else if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_last_q   <= 1'b1;
						m_status_q <= tlpq_pkg::ST_UNF;
						state_q    <= S_IDLE;
					end
				end
				S_DEQ_WAIT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_last_q   <= (rem_q == CW'(1));
						m_status_q <= tlpq_pkg::ST_DEQ;
						if (rem_q == CW'(1)) begin
							state_q <= S_IDLE;
						end else if (!any_data) begin
							// let the exec step close the burst with an underflow beat
							state_q <= S_EXEC;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_q <= s_tuser;
			data_q <= in_data;
			pri_q  <= in_pri;
			rem_q  <= burst_n;
		end else if ((state_q == S_DEQ_WAIT) && out_free) begin
			rem_q <= CW'(rem_q - 1'b1);
		end
		if (rd_en) begin
			rd_lvl_s1 <= pick_lvl;
		end
		if ((state_q == S_DEQ_WAIT) && out_free) begin
			m_data_q  <= rd_data;
			m_level_q <= rd_lvl_s1;
		end else if ((state_q == S_EXEC) && out_free) begin
			m_data_q  <= '0;
			m_level_q <= '0;
		end
	end

	always_comb begin
		m_tdata = '0;
		m_tdata[DATA_WIDTH-1:0]    = m_data_q;
		m_tdata[DATA_WIDTH +: LW]  = m_level_q;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_status_q;
	assign m_tlast  = m_last_q;

	// no level ever counts more entries than it can hold
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q[0] <= OW'(DEPTH)) && (occ_q[1] <= OW'(DEPTH)) && (occ_q[2] <= OW'(DEPTH)))
		else $error("level occupancy above depth");

	// a read never targets an empty level
	a_rd_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (occ_q[pick_lvl] != '0))
		else $error("read issued from an empty level");

	// reads and writes never share a cycle
	a_rd_wr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && wr_en))
		else $error("read and write in the same cycle");

	// hold a stalled result beat unchanged
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tready) |=>
			(m_tvalid_q && $stable(m_tuser) && $stable(m_tlast) && $stable(m_tdata)))
		else $error("output register overwritten while stalled");

	// a burst that is not finished keeps the block busy
	a_burst_busy: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DEQ_WAIT) && out_free && (rem_q != CW'(1))) |=> (state_q != S_IDLE))
		else $error("burst ended early");

endmodule
